// ----- hw/rtl/ecl_pkg.sv -----
// ecl_pkg: shared widths, codes and the header record type of the
// ethernet frame classifier. No dependencies; imported by every module.
package ecl_pkg;

  // byte counter width; the counter saturates at its all-ones value
  localparam int LENGTH_BITS = 14;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

  // width used for length arithmetic in the classifier
  localparam int LEN_EXT_W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

  // header record queue between parser and classifier
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [1:0] REG_MMS_PORT    = 2'd0;
  localparam logic [1:0] REG_IEC104_PORT = 2'd1;
  localparam logic [1:0] REG_SNTP_PORT   = 2'd2;

  localparam logic [15:0] MMS_PORT_RST    = 16'd102;
  localparam logic [15:0] IEC104_PORT_RST = 16'd2404;
  localparam logic [15:0] SNTP_PORT_RST   = 16'd123;

  // ethertypes in network order
  localparam logic [15:0] ET_VLAN  = 16'h8100;
  localparam logic [15:0] ET_IPV4  = 16'h0800;
  localparam logic [15:0] ET_ARP   = 16'h0806;
  localparam logic [15:0] ET_GOOSE = 16'h88B8;
  localparam logic [15:0] ET_SV    = 16'h88BA;
  localparam logic [15:0] ET_PTP   = 16'h88F7;

  // ip protocol numbers
  localparam logic [7:0] IPP_ICMP = 8'h01;
  localparam logic [7:0] IPP_TCP  = 8'h06;
  localparam logic [7:0] IPP_UDP  = 8'h11;

  // header offsets
  localparam logic [4:0] ETH_HDR_LEN  = 5'd14;
  localparam logic [4:0] VLAN_HDR_LEN = 5'd18;

  // protocol classes
  localparam logic [3:0] CLS_ETH    = 4'd0;
  localparam logic [3:0] CLS_ARP    = 4'd1;
  localparam logic [3:0] CLS_IP     = 4'd2;
  localparam logic [3:0] CLS_TCP    = 4'd3;
  localparam logic [3:0] CLS_UDP    = 4'd4;
  localparam logic [3:0] CLS_ICMP   = 4'd5;
  localparam logic [3:0] CLS_MMS    = 4'd6;
  localparam logic [3:0] CLS_IEC104 = 4'd7;
  localparam logic [3:0] CLS_SNTP   = 4'd8;
  localparam logic [3:0] CLS_GOOSE  = 4'd9;
  localparam logic [3:0] CLS_SV     = 4'd10;
  localparam logic [3:0] CLS_PTP    = 4'd11;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_IP_LENGTH   = 3'd1;
  localparam logic [2:0] ERR_TCP_SHORT   = 3'd2;
  localparam logic [2:0] ERR_UDP_SHORT   = 3'd3;
  localparam logic [2:0] ERR_FRAME_SHORT = 3'd4;

  // header fields of one finished frame
  typedef struct packed {
    logic [LENGTH_BITS-1:0] frame_len;
    logic [15:0]            ether_type;
    logic                   vlan_seen;
    logic [5:0]             ip_header_bytes;
    logic [15:0]            ip_total_length;
    logic [7:0]             ip_protocol;
    logic [15:0]            source_port;
    logic [15:0]            destination_port;
    logic [5:0]             tcp_header_bytes;
  } hdr_rec_t;

endpackage

// ----- hw/rtl/ecl_parser.sv -----
// ecl_parser: front part; counts frame bytes and captures header fields,
// handing one header record per frame to the queue. Depends on ecl_pkg.
module ecl_parser
  import ecl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       rec_write,
  output hdr_rec_t   rec
);

  logic [LENGTH_BITS-1:0] byte_count;
  logic [15:0]            ether_type;
  logic                   vlan_seen;
  logic [5:0]             ip_header_bytes;
  logic [15:0]            ip_total_length;
  logic [7:0]             ip_protocol;
  logic [15:0]            source_port;
  logic [15:0]            destination_port;
  logic [5:0]             tcp_header_bytes;

  logic [LENGTH_BITS-1:0] byte_count_next;
  logic [15:0]            ether_type_next;
  logic                   vlan_seen_next;
  logic [5:0]             ip_header_bytes_next;
  logic [15:0]            ip_total_length_next;
  logic [7:0]             ip_protocol_next;
  logic [15:0]            source_port_next;
  logic [15:0]            destination_port_next;
  logic [5:0]             tcp_header_bytes_next;

  logic [LENGTH_BITS-1:0] pos;
  logic [4:0]             base;
  logic [6:0]             l4;
  logic [LENGTH_BITS-1:0] base_x;
  logic [LENGTH_BITS-1:0] l4_x;

  assign pos    = byte_count;
  assign base   = vlan_seen ? VLAN_HDR_LEN : ETH_HDR_LEN;
  assign l4     = 7'(base) + 7'(ip_header_bytes);
  assign base_x = LENGTH_BITS'(base);
  assign l4_x   = LENGTH_BITS'(l4);

  // header field capture for the byte at the current position
  always_comb begin
    ether_type_next       = ether_type;
    vlan_seen_next        = vlan_seen;
    ip_header_bytes_next  = ip_header_bytes;
    ip_total_length_next  = ip_total_length;
    ip_protocol_next      = ip_protocol;
    source_port_next      = source_port;
    destination_port_next = destination_port;
    tcp_header_bytes_next = tcp_header_bytes;
    if (pos == LENGTH_BITS'(12) || pos == LENGTH_BITS'(13)) begin
      ether_type_next = {ether_type[7:0], data_byte};
      if (pos == LENGTH_BITS'(13) && ether_type_next == ET_VLAN) begin
        vlan_seen_next = 1'b1;
      end
    end else if (vlan_seen && (pos == LENGTH_BITS'(16) || pos == LENGTH_BITS'(17))) begin
      ether_type_next = {ether_type[7:0], data_byte};
    end else if (pos >= base_x && ether_type == ET_IPV4) begin
      if (pos == base_x) begin
        ip_header_bytes_next = {data_byte[3:0], 2'b00};
      end else if (pos == base_x + LENGTH_BITS'(2) || pos == base_x + LENGTH_BITS'(3)) begin
        ip_total_length_next = {ip_total_length[7:0], data_byte};
      end else if (pos == base_x + LENGTH_BITS'(9)) begin
        ip_protocol_next = data_byte;
      end
      // transport fields, only once a sane ihl is known
      if (ip_header_bytes >= 6'd20) begin
        if (pos == l4_x || pos == l4_x + LENGTH_BITS'(1)) begin
          source_port_next = {source_port[7:0], data_byte};
        end else if (pos == l4_x + LENGTH_BITS'(2) || pos == l4_x + LENGTH_BITS'(3)) begin
          destination_port_next = {destination_port[7:0], data_byte};
        end else if (pos == l4_x + LENGTH_BITS'(12)) begin
          tcp_header_bytes_next = {data_byte[7:4], 2'b00};
        end
      end
    end
  end

  // saturating byte counter
  assign byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 1'b1 : byte_count;

  // record of the finished frame
  assign rec_write = take && last_byte;
  always_comb begin
    rec.frame_len        = byte_count_next;
    rec.ether_type       = ether_type_next;
    rec.vlan_seen        = vlan_seen_next;
    rec.ip_header_bytes  = ip_header_bytes_next;
    rec.ip_total_length  = ip_total_length_next;
    rec.ip_protocol      = ip_protocol_next;
    rec.source_port      = source_port_next;
    rec.destination_port = destination_port_next;
    rec.tcp_header_bytes = tcp_header_bytes_next;
  end

  // frame state, cleared after every last byte
  always_ff @(posedge clk) begin
    if (rst || rec_write) begin
      byte_count       <= '0;
      ether_type       <= '0;
      vlan_seen        <= 1'b0;
      ip_header_bytes  <= '0;
      ip_total_length  <= '0;
      ip_protocol      <= '0;
      source_port      <= '0;
      destination_port <= '0;
      tcp_header_bytes <= '0;
    end else if (take) begin
      byte_count       <= byte_count_next;
      ether_type       <= ether_type_next;
      vlan_seen        <= vlan_seen_next;
      ip_header_bytes  <= ip_header_bytes_next;
      ip_total_length  <= ip_total_length_next;
      ip_protocol      <= ip_protocol_next;
      source_port      <= source_port_next;
      destination_port <= destination_port_next;
      tcp_header_bytes <= tcp_header_bytes_next;
    end
  end

endmodule

// ----- hw/rtl/ecl_queue.sv -----
// ecl_queue: short first-in first-out queue of header records between
// the parser and the classifier. Depends on ecl_pkg.
module ecl_queue
  import ecl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  hdr_rec_t wr_rec,
  output logic     q_full,
  input  logic     rd_en,
  output hdr_rec_t rd_rec,
  output logic     q_empty
);

  hdr_rec_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign q_full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign rd_rec  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/ecl_classify.sv -----
// ecl_classify: back part; holds the port registers, classifies one header
// record per cycle into the result register when it can take one. Depends on ecl_pkg.
module ecl_classify
  import ecl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        rec_avail,
  input  hdr_rec_t    rec,
  output logic        rec_take,
  input  logic        res_pop,
  output logic        res_valid,
  output logic [3:0]  protocol_class,
  output logic [2:0]  error_code,
  output logic [7:0]  payload_offset,
  output logic [13:0] valid_bytes,
  output logic        vlan_present
);

  logic [15:0] mms_port;
  logic [15:0] iec104_port;
  logic [15:0] sntp_port;

  logic [4:0]           pos;
  logic [6:0]           l4;
  logic [LEN_EXT_W-1:0] len_x;
  logic [LEN_EXT_W-1:0] pos_x;
  logic [LEN_EXT_W-1:0] l4_x;
  logic [LEN_EXT_W-1:0] rem;
  logic [LEN_EXT_W-1:0] trimmed;
  logic                 frame_short;
  logic                 ip_bad;
  logic                 tcp_short;
  logic                 udp_short;
  logic                 hit_mms;
  logic                 hit_iec104;
  logic                 hit_sntp;

  logic [3:0]  cls_next;
  logic [2:0]  err_next;
  logic [7:0]  off_next;
  logic [13:0] vb_next;

  // port registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mms_port    <= MMS_PORT_RST;
      iec104_port <= IEC104_PORT_RST;
      sntp_port   <= SNTP_PORT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MMS_PORT:    mms_port    <= cfg_data;
        REG_IEC104_PORT: iec104_port <= cfg_data;
        REG_SNTP_PORT:   sntp_port   <= cfg_data;
        default: ;
      endcase
    end
  end

  // length checks, all in parallel
  assign pos         = rec.vlan_seen ? VLAN_HDR_LEN : ETH_HDR_LEN;
  assign l4          = 7'(pos) + 7'(rec.ip_header_bytes);
  assign len_x       = LEN_EXT_W'(rec.frame_len);
  assign pos_x       = LEN_EXT_W'(pos);
  assign l4_x        = LEN_EXT_W'(l4);
  assign rem         = len_x - pos_x;
  assign trimmed     = pos_x + LEN_EXT_W'(rec.ip_total_length);
  assign frame_short = len_x < pos_x;
  assign ip_bad      = (rem < LEN_EXT_W'(20)) || (rec.ip_header_bytes < 6'd20) ||
                       (LEN_EXT_W'(rec.ip_total_length) > rem);
  assign tcp_short   = len_x < l4_x + LEN_EXT_W'(20);
  assign udp_short   = len_x < l4_x + LEN_EXT_W'(8);

  // port matches
  assign hit_mms    = (rec.source_port == mms_port) || (rec.destination_port == mms_port);
  assign hit_iec104 = (rec.source_port == iec104_port) ||
                      (rec.destination_port == iec104_port);
  assign hit_sntp   = (rec.source_port == sntp_port) || (rec.destination_port == sntp_port);

  // class selection
  always_comb begin
    cls_next = CLS_ETH;
    err_next = ERR_NONE;
    off_next = 8'(pos);
    vb_next  = len_x[13:0];
    if (frame_short) begin
      err_next = ERR_FRAME_SHORT;
      off_next = '0;
    end else begin
      unique case (rec.ether_type)
        ET_IPV4: begin
          if (ip_bad) begin
            cls_next = CLS_IP;
            err_next = ERR_IP_LENGTH;
            off_next = '0;
          end else begin
            vb_next = trimmed[13:0];
            if (rec.ip_protocol == IPP_TCP) begin
              if (tcp_short) begin
                cls_next = CLS_TCP;
                err_next = ERR_TCP_SHORT;
                off_next = '0;
              end else if (hit_mms) begin
                cls_next = CLS_MMS;
                off_next = 8'(l4) + 8'(rec.tcp_header_bytes);
              end else if (hit_iec104) begin
                cls_next = CLS_IEC104;
                off_next = 8'(l4) + 8'(rec.tcp_header_bytes);
              end else begin
                cls_next = CLS_TCP;
                off_next = 8'(l4);
              end
            end else if (rec.ip_protocol == IPP_UDP) begin
              if (udp_short) begin
                cls_next = CLS_UDP;
                err_next = ERR_UDP_SHORT;
                off_next = '0;
              end else if (hit_sntp) begin
                cls_next = CLS_SNTP;
                off_next = 8'(l4) + 8'd8;
              end else begin
                cls_next = CLS_UDP;
                off_next = 8'(l4);
              end
            end else if (rec.ip_protocol == IPP_ICMP) begin
              cls_next = CLS_ICMP;
              off_next = 8'(l4);
            end else begin
              cls_next = CLS_IP;
            end
          end
        end
        ET_ARP:   cls_next = CLS_ARP;
        ET_GOOSE: cls_next = CLS_GOOSE;
        ET_SV:    cls_next = CLS_SV;
        ET_PTP:   cls_next = CLS_PTP;
        default:  cls_next = CLS_ETH;
      endcase
    end
  end

  // result register; refills in the cycle its word is popped
  assign rec_take = rec_avail && (!res_valid || res_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rec_take) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_take) begin
      protocol_class <= cls_next;
      error_code     <= err_next;
      payload_offset <= off_next;
      valid_bytes    <= vb_next;
      vlan_present   <= rec.vlan_seen;
    end
  end

endmodule

// ----- hw/rtl/ethernet_frame_classifier.sv -----
// ethernet_frame_classifier: top level; parser front, record queue and
// classifier back. Depends on ecl_pkg, ecl_parser, ecl_queue, ecl_classify.
//
//  channel   handshake        word
//  -------   ---------        ----
//  input     push / full      data_byte, last_byte
//  result    empty / pop      protocol_class, error_code, payload_offset,
//                             valid_bytes, vlan_present
//  config    cfg_write        cfg_index, cfg_data
//
// One byte is taken every cycle while full is low; the parser keeps per-frame
// header state. When a frame's last byte is taken, the accepting edge writes
// its record into the queue; the classifier output for it is then loaded into
// the result register when that register is empty or being popped.
// full rises only when the four-entry record queue is full, which needs the
// result side to hold off pops over several frames.
// Reset (rst, synchronous) clears the frame state, empties the queue and
// restores the port registers to 102, 2404 and 123.
module ethernet_frame_classifier
  import ecl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  protocol_class,
  output logic [2:0]  error_code,
  output logic [7:0]  payload_offset,
  output logic [13:0] valid_bytes,
  output logic        vlan_present,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic     take;
  logic     rec_write;
  hdr_rec_t wr_rec;
  hdr_rec_t rd_rec;
  logic     q_full;
  logic     q_empty;
  logic     rec_take;
  logic     res_valid;

  assign full  = q_full;
  assign take  = push && !q_full;
  assign empty = !res_valid;

  // front: byte parser
  ecl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .rec_write (rec_write),
    .rec       (wr_rec)
  );

  // record queue
  ecl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_write),
    .wr_rec  (wr_rec),
    .q_full  (q_full),
    .rd_en   (rec_take),
    .rd_rec  (rd_rec),
    .q_empty (q_empty)
  );

  // back: classifier and result register
  ecl_classify u_classify (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rec_avail      (!q_empty),
    .rec            (rd_rec),
    .rec_take       (rec_take),
    .res_pop        (pop),
    .res_valid      (res_valid),
    .protocol_class (protocol_class),
    .error_code     (error_code),
    .payload_offset (payload_offset),
    .valid_bytes    (valid_bytes),
    .vlan_present   (vlan_present)
  );

endmodule

// ----- sim/testbench.sv -----
// testbench: self-checking bench for ethernet_frame_classifier, byte-wide
// frames in, one verdict per frame out. Depends on ecl_pkg and the rtl.
`timescale 1ns / 1ps

module testbench;
  import ecl_pkg::*;

  localparam int         CYCLE_LIMIT   = 1000000;
  localparam int         LONG_HOLD     = 800;
  localparam int         SETTLE_CYCLES = 6;
  localparam logic [1:0] REG_UNUSED    = 2'd3;
  localparam logic [15:0] ET_LLDP      = 16'h88CC;
  localparam logic [7:0]  IPP_IGMP     = 8'h02;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  typedef struct {
    logic [3:0]  cls;
    logic [2:0]  err;
    logic [7:0]  offset;
    logic [13:0] valid;
    logic        vlan;
  } frame_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  protocol_class;
  logic [2:0]  error_code;
  logic [7:0]  payload_offset;
  logic [13:0] valid_bytes;
  logic        vlan_present;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;

  ethernet_frame_classifier dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .empty(empty),
    .pop(pop),
    .protocol_class(protocol_class),
    .error_code(error_code),
    .payload_offset(payload_offset),
    .valid_bytes(valid_bytes),
    .vlan_present(vlan_present),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and scoreboard storage
  byte_word_t     pending_words[$];
  logic [7:0]     frame_buf[$];
  frame_verdict_t expected_verdicts[$];
  byte_word_t     next_word;
  int frames_queued = 0;
  int bytes_queued = 0;
  int verdicts_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int phase = 0;
  bit idle_on = 1'b1;
  bit long_hold_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  // port registers as the block should hold them
  logic [15:0] port_mms    = MMS_PORT_RST;
  logic [15:0] port_iec104 = IEC104_PORT_RST;
  logic [15:0] port_sntp   = SNTP_PORT_RST;

  // per-frame header state of the parser
  int          fr_count = 0;
  logic [15:0] fr_type = 16'h0000;
  logic        fr_vlan = 1'b0;
  int          fr_ihl_bytes = 0;
  logic [15:0] fr_total = 16'h0000;
  logic [7:0]  fr_proto = 8'h00;
  logic [15:0] fr_sport = 16'h0000;
  logic [15:0] fr_dport = 16'h0000;
  int          fr_tcp_bytes = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    // keep the log short if the block goes badly wrong
    if (mismatch_count <= 100)
      $display("mismatch on frame %0d: %s got %0d expected %0d",
               verdicts_checked, what, got, want);
  endtask

  // parse one accepted byte; at the last byte classify the frame
  task automatic track_byte(input logic [7:0] b, input logic lastb);
    int p, base, l4, flen, pos;
    frame_verdict_t v;
    p = fr_count;
    base = fr_vlan ? VLAN_HDR_LEN : ETH_HDR_LEN;
    if (p == 12 || p == 13) begin
      fr_type = {fr_type[7:0], b};
      if (p == 13 && fr_type == ET_VLAN) fr_vlan = 1'b1;
    end else if (fr_vlan && (p == 16 || p == 17)) begin
      fr_type = {fr_type[7:0], b};
    end else if (p >= base && fr_type == ET_IPV4) begin
      if (p == base) fr_ihl_bytes = 4 * int'(b[3:0]);
      else if (p == base + 2 || p == base + 3) fr_total = {fr_total[7:0], b};
      else if (p == base + 9) fr_proto = b;
      if (fr_ihl_bytes >= 20) begin
        l4 = base + fr_ihl_bytes;
        if (p == l4 || p == l4 + 1) fr_sport = {fr_sport[7:0], b};
        else if (p == l4 + 2 || p == l4 + 3) fr_dport = {fr_dport[7:0], b};
        else if (p == l4 + 12) fr_tcp_bytes = 4 * int'(b[7:4]);
      end
    end
    // counter saturates
    if (fr_count < int'(COUNT_MAX)) fr_count++;
    if (!lastb) return;

    flen = fr_count;
    pos = fr_vlan ? VLAN_HDR_LEN : ETH_HDR_LEN;
    v.cls = CLS_ETH;
    v.err = ERR_NONE;
    v.offset = 8'd0;
    v.valid = 14'(flen);
    v.vlan = fr_vlan;
    if (flen < pos) begin
      v.err = ERR_FRAME_SHORT;
    end else if (fr_type == ET_IPV4) begin
      if (flen - pos < 20 || fr_ihl_bytes < 20 || int'(fr_total) > flen - pos) begin
        v.cls = CLS_IP;
        v.err = ERR_IP_LENGTH;
      end else begin
        v.valid = 14'(pos + int'(fr_total));
        l4 = pos + fr_ihl_bytes;
        case (fr_proto)
          IPP_TCP: begin
            if (flen < l4 || flen - l4 < 20) begin
              v.cls = CLS_TCP;
              v.err = ERR_TCP_SHORT;
            end else if (fr_sport == port_mms || fr_dport == port_mms) begin
              v.cls = CLS_MMS;
              v.offset = 8'(l4 + fr_tcp_bytes);
            end else if (fr_sport == port_iec104 || fr_dport == port_iec104) begin
              v.cls = CLS_IEC104;
              v.offset = 8'(l4 + fr_tcp_bytes);
            end else begin
              v.cls = CLS_TCP;
              v.offset = 8'(l4);
            end
          end
          IPP_UDP: begin
            if (flen < l4 || flen - l4 < 8) begin
              v.cls = CLS_UDP;
              v.err = ERR_UDP_SHORT;
            end else if (fr_sport == port_sntp || fr_dport == port_sntp) begin
              v.cls = CLS_SNTP;
              v.offset = 8'(l4 + 8);
            end else begin
              v.cls = CLS_UDP;
              v.offset = 8'(l4);
            end
          end
          IPP_ICMP: begin
            v.cls = CLS_ICMP;
            v.offset = 8'(l4);
          end
          default: begin
            v.cls = CLS_IP;
            v.offset = 8'(pos);
          end
        endcase
      end
    end else begin
      case (fr_type)
        ET_ARP:   v.cls = CLS_ARP;
        ET_GOOSE: v.cls = CLS_GOOSE;
        ET_SV:    v.cls = CLS_SV;
        ET_PTP:   v.cls = CLS_PTP;
        default:  v.cls = CLS_ETH;
      endcase
      v.offset = 8'(pos);
    end
    expected_verdicts.push_back(v);

    // fresh header state for the next frame
    fr_count = 0;
    fr_type = 16'h0000;
    fr_vlan = 1'b0;
    fr_ihl_bytes = 0;
    fr_total = 16'h0000;
    fr_proto = 8'h00;
    fr_sport = 16'h0000;
    fr_dport = 16'h0000;
    fr_tcp_bytes = 0;
  endtask

  task automatic check_verdict();
    frame_verdict_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("result with no frame pending, class", protocol_class, 0);
    end else begin
      want = expected_verdicts.pop_front();
      if (protocol_class !== want.cls)
        report_mismatch("protocol_class", protocol_class, want.cls);
      if (error_code !== want.err)
        report_mismatch("error_code", error_code, want.err);
      if (payload_offset !== want.offset)
        report_mismatch("payload_offset", payload_offset, want.offset);
      if (valid_bytes !== want.valid)
        report_mismatch("valid_bytes", valid_bytes, want.valid);
      if (vlan_present !== want.vlan)
        report_mismatch("vlan_present", vlan_present, want.vlan);
    end
    verdicts_checked++;
  endtask

  // header byte i of a frame with an optional tag
  function automatic logic [7:0] eth_byte(input int i, input logic vlan_f,
                                          input logic [15:0] etype);
    logic [15:0] w;
    w = (vlan_f && i < 14) ? ET_VLAN : etype;
    if (i == 12 || (vlan_f && i == 16)) return w[15:8];
    if (i == 13 || (vlan_f && i == 17)) return w[7:0];
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 7))
      0: return port_mms;
      1: return port_iec104;
      2: return port_sntp;
      3: return 16'h0000;
      4: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_ethertype();
    case ($urandom_range(0, 6))
      0: return ET_ARP;
      1: return ET_GOOSE;
      2: return ET_SV;
      3: return ET_PTP;
      4: return ET_IPV4;
      5: return ET_VLAN;
      default: return 16'($urandom);
    endcase
  endfunction

  // move the built frame into the pending words
  task automatic flush_frame();
    byte_word_t w;
    foreach (frame_buf[i]) begin
      w.data = frame_buf[i];
      w.last = (i == frame_buf.size() - 1);
      pending_words.push_back(w);
    end
    frames_queued++;
    bytes_queued += frame_buf.size();
    frame_buf.delete();
  endtask

  // frame of n bytes in all: ethernet type fields at their offsets, random content elsewhere
  task automatic add_raw_frame(input int n, input logic vlan_f, input logic [15:0] etype);
    for (int i = 0; i < n; i++) frame_buf.push_back(eth_byte(i, vlan_f, etype));
    flush_frame();
  endtask

  // ipv4 frame; the total length field is header + l4_len + tot_adj
  task automatic add_ipv4_frame(input logic vlan_f, input int ihl, input logic [7:0] proto,
                                input logic [15:0] sport, input logic [15:0] dport,
                                input int doff, input int l4_len, input int pad,
                                input int tot_adj);
    int pos, hlen, total;
    logic [15:0] tot16;
    logic [7:0] b;
    pos = vlan_f ? VLAN_HDR_LEN : ETH_HDR_LEN;
    hlen = (ihl < 5) ? 20 : ihl * 4;
    total = hlen + l4_len + tot_adj;
    if (total < 0) total = 0;
    tot16 = 16'(total);
    for (int i = 0; i < pos; i++) frame_buf.push_back(eth_byte(i, vlan_f, ET_IPV4));
    for (int i = 0; i < hlen; i++) begin
      case (i)
        0: b = {4'h4, 4'(ihl)};
        2: b = tot16[15:8];
        3: b = tot16[7:0];
        9: b = proto;
        default: b = 8'($urandom);
      endcase
      frame_buf.push_back(b);
    end
    for (int i = 0; i < l4_len; i++) begin
      case (i)
        0: b = sport[15:8];
        1: b = sport[7:0];
        2: b = dport[15:8];
        3: b = dport[7:0];
        12: b = {4'(doff), 4'($urandom)};
        default: b = 8'($urandom);
      endcase
      frame_buf.push_back(b);
    end
    for (int i = 0; i < pad; i++) frame_buf.push_back(8'($urandom));
    flush_frame();
  endtask

  // mostly well-formed ip traffic, the rest runts, other types and junk headers
  task automatic add_random_frames(input int min_frames, input int min_bytes);
    int f0, b0, r, ihl, doff, l4_len, pad, adj;
    logic vlan_f;
    logic [7:0] proto;
    f0 = frames_queued;
    b0 = bytes_queued;
    while (frames_queued - f0 < min_frames || bytes_queued - b0 < min_bytes) begin
      r = $urandom_range(0, 99);
      vlan_f = ($urandom_range(0, 3) == 0);
      if (r < 8) begin
        add_raw_frame($urandom_range(1, 19), vlan_f, pick_ethertype());
      end else if (r < 22) begin
        add_raw_frame((vlan_f ? 18 : 14) + $urandom_range(0, 40), vlan_f, pick_ethertype());
      end else if (r < 32) begin
        add_ipv4_frame(vlan_f, $urandom_range(0, 15), 8'($urandom), pick_port(), pick_port(),
                       $urandom_range(0, 15), $urandom_range(0, 40), $urandom_range(0, 8),
                       int'($urandom_range(0, 80)) - 40);
      end else begin
        ihl = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
        doff = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            proto = IPP_TCP;
            l4_len = doff * 4 + $urandom_range(0, 30);
          end
          5, 6, 7: begin
            proto = IPP_UDP;
            l4_len = 8 + $urandom_range(0, 30);
          end
          8: begin
            proto = IPP_ICMP;
            l4_len = $urandom_range(0, 30);
          end
          default: begin
            proto = 8'($urandom);
            l4_len = $urandom_range(0, 30);
          end
        endcase
        // short or barely long enough transport headers
        if ($urandom_range(0, 7) == 0) l4_len = $urandom_range(0, 24);
        pad = $urandom_range(0, 1) ? 0 : $urandom_range(1, 24);
        adj = ($urandom_range(0, 9) == 0) ? pad + $urandom_range(1, 3) : 0;
        add_ipv4_frame(vlan_f, ihl, proto, pick_port(), pick_port(), doff, l4_len, pad, adj);
      end
    end
  endtask

  task automatic write_port_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_MMS_PORT:    port_mms = val;
      REG_IEC104_PORT: port_iec104 = val;
      REG_SNTP_PORT:   port_sntp = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // wait until every word is in and every verdict is out, then let it settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || push || expected_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // byte driver: offers pending words, predicts each accepted word
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) track_byte(data_byte, last_byte);
      if (!push || !full) begin
        if (send_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
          send_gap = $urandom_range(1, 11);
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_word = pending_words.pop_front();
          push <= 1'b1;
          data_byte <= next_word.data;
          last_byte <= next_word.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // verdict monitor: pops with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      recv_gap = 0;
    end else begin
      if (pop && !empty) check_verdict();
      if (phase == 1 && !long_hold_done) begin
        long_hold_done = 1'b1;
        recv_gap = LONG_HOLD;
      end else if (recv_gap == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 11);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : main_sequence
    logic [15:0] shared_port;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed frames with the reset port values
    add_raw_frame(1, 1'b0, ET_ARP);
    add_raw_frame(13, 1'b0, ET_IPV4);
    add_raw_frame(17, 1'b1, ET_IPV4);
    add_raw_frame(14, 1'b0, ET_PTP);
    add_raw_frame(20, 1'b0, ET_ARP);
    add_raw_frame(22, 1'b1, ET_GOOSE);
    add_raw_frame(20, 1'b0, ET_SV);
    add_raw_frame(20, 1'b0, ET_LLDP);
    // second tag is not skipped
    add_raw_frame(24, 1'b1, ET_VLAN);
    // ip frame with fewer than twenty bytes after the header
    add_raw_frame(33, 1'b0, ET_IPV4);
    // header length field below five words
    add_ipv4_frame(1'b0, 4, IPP_TCP, 16'd5000, 16'd80, 5, 20, 0, 0);
    // total length past the end of the frame
    add_ipv4_frame(1'b0, 5, IPP_UDP, 16'd5000, 16'd53, 0, 8, 2, 3);
    add_ipv4_frame(1'b0, 5, IPP_TCP, 16'd40000, 16'd80, 5, 24, 2, 0);
    add_ipv4_frame(1'b0, 5, IPP_TCP, 16'd40000, MMS_PORT_RST, 8, 32, 4, 0);
    add_ipv4_frame(1'b1, 15, IPP_TCP, IEC104_PORT_RST, 16'd40000, 15, 24, 0, 0);
    // both ports match, mms wins
    add_ipv4_frame(1'b0, 5, IPP_TCP, IEC104_PORT_RST, MMS_PORT_RST, 5, 20, 0, 0);
    add_ipv4_frame(1'b0, 5, IPP_TCP, 16'd1, 16'd2, 5, 19, 0, 0);
    add_ipv4_frame(1'b0, 5, IPP_UDP, 16'd40000, SNTP_PORT_RST, 0, 12, 0, 0);
    add_ipv4_frame(1'b1, 6, IPP_UDP, 16'd1000, 16'd2000, 0, 12, 6, 0);
    add_ipv4_frame(1'b0, 5, IPP_UDP, 16'd1, 16'd2, 0, 7, 0, 0);
    add_ipv4_frame(1'b0, 5, IPP_ICMP, 16'd0, 16'd0, 0, 8, 0, 0);
    add_ipv4_frame(1'b0, 5, IPP_IGMP, 16'd0, 16'd0, 0, 8, 4, 0);
    wait_drained();

    // random ports, long result stall over a burst of short frames
    phase = 1;
    write_port_reg(REG_MMS_PORT, 16'($urandom));
    write_port_reg(REG_IEC104_PORT, 16'($urandom));
    write_port_reg(REG_SNTP_PORT, 16'($urandom));
    write_port_reg(REG_UNUSED, 16'($urandom));
    repeat (5) add_raw_frame($urandom_range(1, 30), 1'b0, pick_ethertype());
    add_random_frames(2, 0);
    wait_drained();

    // low and high port extremes
    phase = 2;
    write_port_reg(REG_MMS_PORT, 16'h0000);
    write_port_reg(REG_IEC104_PORT, 16'hFFFF);
    write_port_reg(REG_SNTP_PORT, 16'h0000);
    add_random_frames(1, 0);
    wait_drained();

    phase = 3;
    write_port_reg(REG_MMS_PORT, 16'hFFFF);
    write_port_reg(REG_IEC104_PORT, 16'h0000);
    write_port_reg(REG_SNTP_PORT, 16'hFFFF);
    add_random_frames(1, 0);
    wait_drained();

    // mms and iec104 on the same port, no idling
    phase = 4;
    idle_on = 1'b0;
    shared_port = 16'($urandom);
    write_port_reg(REG_MMS_PORT, shared_port);
    write_port_reg(REG_IEC104_PORT, shared_port);
    write_port_reg(REG_SNTP_PORT, 16'($urandom));
    add_random_frames(2, 0);
    wait_drained();

    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ecl_pkg.sv
hw/rtl/ecl_parser.sv
hw/rtl/ecl_queue.sv
hw/rtl/ecl_classify.sv
hw/rtl/ethernet_frame_classifier.sv
sim/testbench.sv
